### sv/ahs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahs_pkg
// Shared types and constants of the additive harmonic synthesiser: register
// map, microcode control word, status word and datapath widths.
// ----------------------------------------------------------------------------
package ahs_pkg;

    // configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PHASE_STEP     = 3'd0;
    localparam t_cfg_idx CFG_START_PHASE    = 3'd1;
    localparam t_cfg_idx CFG_BASE_AMPLITUDE = 3'd2;
    localparam t_cfg_idx CFG_HARMONIC_COUNT = 3'd3;
    localparam t_cfg_idx CFG_RATIO_WORD     = 3'd4;
    localparam t_cfg_idx CFG_LEVEL_WORD     = 3'd5;
    localparam t_cfg_idx CFG_SAMPLE_COUNT   = 3'd6;

    // fixed field widths
    localparam int AMP_W     = 15;
    localparam int LVL_W     = 8;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = 24;
    localparam int SIN_W     = 16;
    localparam int MUL_A_W   = 24;   // ratio, amplitude and gain all fit
    localparam int ACC_W     = 42;   // eight terms of 39 bits
    localparam int TERM_FRAC = 39;   // terms are in units of 2^-38, sign bit extra

    typedef struct packed {
        logic [31:0]       phase_step;
        logic [31:0]       start_phase;
        logic [AMP_W-1:0]  base_amplitude;
        logic [CNT_W-1:0]  harmonic_count;
        logic [63:0]       ratio_word;
        logic [63:0]       level_word;
        logic [IDX_W-1:0]  sample_count;
    } t_cfg;

    // microprogram step addresses
    typedef logic [2:0] t_step;
    localparam t_step ST_WAIT = 3'd0;
    localparam t_step ST_CHK  = 3'd1;
    localparam t_step ST_L0   = 3'd2;
    localparam t_step ST_L1   = 3'd3;
    localparam t_step ST_L2   = 3'd4;
    localparam t_step ST_OUT  = 3'd5;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MUL_PHASE,
        MUL_GAIN,
        MUL_TERM
    } t_mul_sel;

    // branch and hold conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_ZERO_COUNT,
        C_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        logic     take_in;
        logic     prod_clr;
        logic     acc_clr;
        logic     acc_add;
        logic     harm_clr;
        logic     harm_inc;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sin_ld;
        logic     emit;
        t_cond    hold;
        t_cond    jump;
        t_step    target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic zero_count;
        logic more;
    } t_status;

    // sine table generation constants (Q30)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;

endpackage
`default_nettype wire

### sv/ahs_sine_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahs_sine_rom
// Quarter-wave sine table with quadrant folding and a registered read.
// ----------------------------------------------------------------------------
module ahs_sine_rom #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [SINE_TABLE_BITS-1:0]  i_phase,
    output logic signed [ahs_pkg::SIN_W-1:0] o_sine
);
    import ahs_pkg::*;

    localparam int QB = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QB;

    // table entry: Taylor series in Q30, scaled to 32767 and rounded
    function automatic logic [SIN_W-2:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        begin
            x  = (64'(k) * HALF_PI_Q30) >> QB;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
            t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
            s  = (x * t) >> 30;
            s  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            return s[SIN_W-2:0];
        end
    endfunction

    logic [SIN_W-2:0] w_tab [QUARTER+1];

    for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
        localparam logic [SIN_W-2:0] V = sine_entry(k);
        assign w_tab[k] = V;
    end

    // quadrant folding: odd quadrants mirror, upper half negates
    logic [1:0]           w_quad;
    logic [QB-1:0]        w_rem;
    logic [QB:0]          w_idx;
    logic signed [SIN_W-1:0] w_mag;
    logic signed [SIN_W-1:0] r_sine;

    assign w_quad = i_phase[SINE_TABLE_BITS-1 -: 2];
    assign w_rem  = i_phase[QB-1:0];
    assign w_idx  = w_quad[0] ? ({1'b1, {QB{1'b0}}} - {1'b0, w_rem}) : {1'b0, w_rem};
    assign w_mag  = {1'b0, w_tab[w_idx]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sine <= w_quad[1] ? (16'sd0 - w_mag) : w_mag;
        end
    end

    assign o_sine = r_sine;

endmodule
`default_nettype wire

### sv/ahs_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahs_sequencer
// Microprogram store and step counter. Each step issues one control word;
// a step may hold on a condition or branch to a target on another.
// ----------------------------------------------------------------------------
module ahs_sequencer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ahs_pkg::t_status i_status,
    output ahs_pkg::t_ctrl       o_ctrl
);
    import ahs_pkg::*;

    // microprogram
    function automatic t_ctrl ucode(input t_step s);
        t_ctrl c;
        begin
            c = '0;
            case (s)
                ST_WAIT: begin
                    c.take_in  = 1'b1;
                    c.prod_clr = 1'b1;
                    c.acc_clr  = 1'b1;
                    c.harm_clr = 1'b1;
                    c.hold     = C_NO_INPUT;
                end
                ST_CHK: begin
                    c.jump   = C_ZERO_COUNT;
                    c.target = ST_OUT;
                end
                ST_L0: begin
                    c.acc_add = 1'b1;
                    c.mul_en  = 1'b1;
                    c.mul_sel = MUL_PHASE;
                end
                ST_L1: begin
                    c.sin_ld  = 1'b1;
                    c.mul_en  = 1'b1;
                    c.mul_sel = MUL_GAIN;
                end
                ST_L2: begin
                    c.mul_en   = 1'b1;
                    c.mul_sel  = MUL_TERM;
                    c.harm_inc = 1'b1;
                    c.jump     = C_MORE;
                    c.target   = ST_L0;
                end
                ST_OUT: begin
                    c.emit   = 1'b1;
                    c.hold   = C_OUT_BUSY;
                    c.jump   = C_ALWAYS;
                    c.target = ST_WAIT;
                end
                default: begin
                    c.jump   = C_ALWAYS;
                    c.target = ST_WAIT;
                end
            endcase
            return c;
        end
    endfunction

    function automatic logic cond_true(input t_cond c, input t_status st);
        logic v;
        begin
            case (c)
                C_NEVER:      v = 1'b0;
                C_ALWAYS:     v = 1'b1;
                C_NO_INPUT:   v = !st.in_valid;
                C_ZERO_COUNT: v = st.zero_count;
                C_MORE:       v = st.more;
                C_OUT_BUSY:   v = st.out_busy;
                default:      v = 1'b0;
            endcase
            return v;
        end
    endfunction

    t_step r_step;
    t_step n_step;
    t_ctrl w_ctrl;

    // next step: hold, branch or fall through
    always_comb begin
        w_ctrl = ucode(r_step);
        if (cond_true(w_ctrl.hold, i_status)) begin
            n_step = r_step;
        end else if (cond_true(w_ctrl.jump, i_status)) begin
            n_step = w_ctrl.target;
        end else begin
            n_step = r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = w_ctrl;

    // checks
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= ST_OUT)
        else $error("step counter left the program");

    a_accept_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.take_in && i_status.in_valid) |=> (r_step == ST_CHK))
        else $error("accepted word did not start the harmonic loop");

    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_OUT && !i_status.out_busy) |=> (r_step == ST_WAIT))
        else $error("sequencer did not return to wait after emitting");

endmodule
`default_nettype wire

### sv/ahs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahs_datapath
// Phase accumulator, shared multiplier, sine lookup, sum accumulator,
// saturation and the output register, all driven by the control word.
// ----------------------------------------------------------------------------
module ahs_datapath #(
    parameter int HARMONICS       = 8,
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32,
    parameter int OUT_BITS        = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ahs_pkg::t_ctrl   i_ctrl,
    input  wire ahs_pkg::t_cfg    i_cfg,
    input  wire logic             i_s_tvalid,
    input  wire logic             i_restart,
    input  wire logic             i_m_tready,
    output ahs_pkg::t_status      o_status,
    output logic                  o_valid,
    output logic [OUT_BITS-1:0]   o_data,
    output logic                  o_last
);
    import ahs_pkg::*;

    localparam int B_W    = PHASE_BITS + 1;
    localparam int PROD_W = MUL_A_W + B_W;
    localparam int SHIFT  = TERM_FRAC - OUT_BITS;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

    logic [PHASE_BITS-1:0]    r_phase;
    logic [IDX_W-1:0]         r_idx;
    logic [CNT_W-1:0]         r_harm;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic [OUT_BITS-1:0]      r_out_data;
    logic                     r_out_last;

    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_emit;
    logic [CNT_W-1:0]         w_count;
    logic                     w_more;
    logic [LVL_W-1:0]         w_ratio;
    logic [LVL_W-1:0]         w_level;
    logic signed [MUL_A_W-1:0] w_a;
    logic signed [B_W-1:0]    w_b;
    logic signed [PROD_W-1:0] w_mul;
    logic [PHASE_BITS-1:0]    w_hphase;
    logic signed [SIN_W-1:0]  w_sin;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [ACC_W-1:0]  w_sum;
    logic signed [ACC_W-1:0]  w_shift;
    logic [OUT_BITS-1:0]      w_sat;
    logic                     w_last;

    assign w_accept   = i_ctrl.take_in && i_s_tvalid;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_emit     = i_ctrl.emit && w_out_free;

    // harmonic loop bound, clamped to the bank size
    assign w_count = (i_cfg.harmonic_count > CNT_W'(HARMONICS)) ?
                     CNT_W'(HARMONICS) : i_cfg.harmonic_count;
    assign w_more  = ({1'b0, r_harm} + 5'd1) < {1'b0, w_count};

    assign w_ratio = i_cfg.ratio_word[{r_harm[2:0], 3'b000} +: LVL_W];
    assign w_level = i_cfg.level_word[{r_harm[2:0], 3'b000} +: LVL_W];

    // shared multiplier operand select
    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_PHASE: begin
                w_a = MUL_A_W'(w_ratio);
                w_b = {1'b0, r_phase};
            end
            MUL_GAIN: begin
                w_a = MUL_A_W'(i_cfg.base_amplitude);
                w_b = B_W'(w_level);
            end
            MUL_TERM: begin
                w_a = r_prod[MUL_A_W-1:0];
                w_b = B_W'(w_sin);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_mul = w_a * w_b;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.prod_clr) begin
            r_prod <= '0;
        end else if (i_ctrl.mul_en) begin
            r_prod <= w_mul;
        end
    end

    // harmonic phase is the product shifted down by the Q4.4 fraction
    assign w_hphase = r_prod[PHASE_BITS+3:4];

    ahs_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .i_clk   (i_clk),
        .i_en    (i_ctrl.sin_ld),
        .i_phase (w_hphase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .o_sine  (w_sin)
    );

    // sum of terms
    assign w_term = ACC_W'(r_prod);
    assign w_sum  = r_acc + w_term;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_add) begin
            r_acc <= w_sum;
        end
    end

    // floor shift and saturate
    assign w_shift = w_sum >>> SHIFT;
    always_comb begin
        if (w_shift > SAT_HI) begin
            w_sat = SAT_HI[OUT_BITS-1:0];
        end else if (w_shift < SAT_LO) begin
            w_sat = SAT_LO[OUT_BITS-1:0];
        end else begin
            w_sat = w_shift[OUT_BITS-1:0];
        end
    end

    assign w_last = ({1'b0, r_idx} + 25'd1) >= {1'b0, i_cfg.sample_count};

    // phase, segment index and harmonic counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_idx   <= '0;
            r_harm  <= '0;
        end else begin
            if (w_accept && i_restart) begin
                r_phase <= i_cfg.start_phase[31 -: PHASE_BITS];
                r_idx   <= '0;
            end else if (w_emit) begin
                r_phase <= r_phase + i_cfg.phase_step[31 -: PHASE_BITS];
                r_idx   <= w_last ? '0 : r_idx + 24'd1;
            end
            if (i_ctrl.harm_clr) begin
                r_harm <= '0;
            end else if (i_ctrl.harm_inc) begin
                r_harm <= r_harm + 4'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= w_sat;
            r_out_last <= w_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

    assign o_status.in_valid   = i_s_tvalid;
    assign o_status.out_busy   = !w_out_free;
    assign o_status.zero_count = (w_count == '0);
    assign o_status.more       = w_more;

    // checks
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_out_valid)
        else $error("emitted sample not presented");

    a_harm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_harm <= CNT_W'(HARMONICS))
        else $error("harmonic counter beyond bank size");

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.acc_clr |=> (r_acc == '0))
        else $error("accumulator not cleared");

endmodule
`default_nettype wire

### sv/additive_harmonic_synth.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// additive_harmonic_synth
// Additive oscillator bank: each input word yields one audio sample, the
// saturated sum of up to eight sine harmonics of a running fundamental phase.
// ----------------------------------------------------------------------------
// Each input word produces one output word. The single shared multiplier is
// used three times per harmonic (harmonic phase, gain, term) under control
// of a six-step microprogram, and the loop runs over the harmonic count
// limited to HARMONICS. One word is worked on at a time; a finished sample
// waits in the output register while the next input word is taken.
// Registers are to be written through the plain write port while the block
// is idle; the user is bound by this, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module additive_harmonic_synth #(
    parameter int HARMONICS       = 8,
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32,
    parameter int OUT_BITS        = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire ahs_pkg::t_cfg_idx                 i_cfg_idx,
    input  wire logic [ahs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [7:0]                        i_s_tdata,  // [0] restart
    // output stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [((OUT_BITS+7)/8)*8-1:0]          o_m_tdata,  // [OUT_BITS-1:0] sample
    output logic                                   o_m_tlast
);
    import ahs_pkg::*;

    localparam int TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    t_cfg                r_cfg;
    t_ctrl               w_ctrl;
    t_status             w_status;
    logic [OUT_BITS-1:0] w_data;

    // configuration registers; all clear except a one-sample segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{sample_count: IDX_W'(1), default: '0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PHASE_STEP:     r_cfg.phase_step     <= i_cfg_data[31:0];
                CFG_START_PHASE:    r_cfg.start_phase    <= i_cfg_data[31:0];
                CFG_BASE_AMPLITUDE: r_cfg.base_amplitude <= i_cfg_data[AMP_W-1:0];
                CFG_HARMONIC_COUNT: r_cfg.harmonic_count <= i_cfg_data[CNT_W-1:0];
                CFG_RATIO_WORD:     r_cfg.ratio_word     <= i_cfg_data;
                CFG_LEVEL_WORD:     r_cfg.level_word     <= i_cfg_data;
                CFG_SAMPLE_COUNT:   r_cfg.sample_count   <= i_cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    ahs_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    ahs_datapath #(
        .HARMONICS       (HARMONICS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS),
        .OUT_BITS        (OUT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .i_restart  (i_s_tdata[0]),
        .i_m_tready (i_m_tready),
        .o_status   (w_status),
        .o_valid    (o_m_tvalid),
        .o_data     (w_data),
        .o_last     (o_m_tlast)
    );

    assign o_s_tready = w_ctrl.take_in;
    assign o_m_tdata  = TDATA_W'(w_data);

endmodule
`default_nettype wire

### test/ahs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahs_checker
// Scoreboard for the additive harmonic synthesiser. It shadows the register
// writes and predicts a sample for every accepted input word from its own
// phase and segment state. Each output word is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module ahs_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  ahs_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [ahs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [7:0]                       i_s_tdata,   // [0] restart
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [23:0]                      i_m_tdata,   // [23:0] sample
    input  logic                             i_m_tlast,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_samples_seen,
    output int                               o_ends_seen,
    output int                               o_clips_seen
);
    import ahs_pkg::*;

    localparam int     SAMPLE_W     = 24;
    localparam int     QUARTER      = 256;            // entries per quarter wave
    localparam int     HARMONIC_MAX = 8;
    localparam int     SUM_SHIFT    = 39 - SAMPLE_W;  // terms are in units of 2^-38
    localparam int     MAX_REPORTS  = 20;
    localparam longint SAMPLE_MAX   = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN   = -SAMPLE_MAX - 1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_synth_word;

    logic signed [15:0] quarter_sine [0:QUARTER];
    t_cfg               regs;
    logic [31:0]        phase_acc;
    logic [IDX_W-1:0]   sample_index;
    t_synth_word        awaited_samples [$];
    int                 fails;
    int                 samples_seen;
    int                 ends_seen;
    int                 clips_seen;

    // quarter-wave sine: Q30 Taylor series in Horner form, truncating steps
    initial begin : build_quarter_sine
        logic [63:0] k64;
        logic [63:0] div;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int k = 0; k <= QUARTER; k++) begin
            k64 = k;
            x   = (k64 * HALF_PI_Q30) / QUARTER;
            x2  = (x * x) >> 30;
            t   = Q30_ONE;
            for (int n = 5; n >= 1; n--) begin
                div = (2 * n) * (2 * n + 1);
                t   = Q30_ONE - (((x2 * t) >> 30) / div);
            end
            s = (x * t) >> 30;
            s = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
            if (s > 64'd32767)
                s = 64'd32767;
            quarter_sine[k] = s[15:0];
        end
    end

    // top ten phase bits pick the entry; odd quadrants mirror, upper half negates
    function automatic logic signed [15:0] sine_at(input logic [31:0] phase);
        logic [9:0]         slot;
        logic [8:0]         tab_idx;
        logic signed [15:0] mag;
        slot    = phase[31:22];
        tab_idx = slot[8] ? QUARTER - slot[7:0] : slot[7:0];
        mag     = quarter_sine[tab_idx];
        return slot[9] ? -mag : mag;
    endfunction

    // one sample of the oscillator bank; advances phase and segment position
    function automatic t_synth_word synthesise_sample(input logic restart);
        t_synth_word res;
        longint      acc;
        logic [39:0] hprod;
        logic [22:0] gain;
        int          voices;
        if (restart) begin
            phase_acc    = regs.start_phase;
            sample_index = '0;
        end
        voices = (regs.harmonic_count > HARMONIC_MAX) ? HARMONIC_MAX : regs.harmonic_count;
        acc    = 0;
        for (int h = 0; h < voices; h++) begin
            hprod = regs.ratio_word[8*h +: 8] * phase_acc;   // Q4.4 ratio
            gain  = regs.base_amplitude * regs.level_word[8*h +: 8];
            acc  += longint'(gain) * longint'(sine_at(hprod[35:4]));
        end
        acc = acc >>> SUM_SHIFT;                             // floor
        if (acc > SAMPLE_MAX)
            acc = SAMPLE_MAX;
        if (acc < SAMPLE_MIN)
            acc = SAMPLE_MIN;
        res.sample   = acc[SAMPLE_W-1:0];
        res.last     = ({1'b0, sample_index} + 25'd1) >= {1'b0, regs.sample_count};
        phase_acc    = phase_acc + regs.phase_step;
        sample_index = res.last ? '0 : sample_index + 1'b1;
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input int want_v, input int got_v);
        fails++;
        if (fails <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    endtask

    // watch all three ports at each edge
    always @(posedge i_clk) begin : track
        t_synth_word want;
        if (!i_rst_n) begin
            regs              = '0;
            regs.sample_count = 24'd1;
            phase_acc         = '0;
            sample_index      = '0;
            awaited_samples.delete();
            fails             = 0;
            samples_seen      = 0;
            ends_seen         = 0;
            clips_seen        = 0;
        end else begin
            // register writes; an index past the map is ignored
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PHASE_STEP:     regs.phase_step     = i_cfg_data[31:0];
                    CFG_START_PHASE:    regs.start_phase    = i_cfg_data[31:0];
                    CFG_BASE_AMPLITUDE: regs.base_amplitude = i_cfg_data[AMP_W-1:0];
                    CFG_HARMONIC_COUNT: regs.harmonic_count = i_cfg_data[CNT_W-1:0];
                    CFG_RATIO_WORD:     regs.ratio_word     = i_cfg_data;
                    CFG_LEVEL_WORD:     regs.level_word     = i_cfg_data;
                    CFG_SAMPLE_COUNT:   regs.sample_count   = i_cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end
            // output first: a word leaving now belongs to an earlier input
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_samples.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t ns: output word, expected none, got sample %0d last %0b",
                                 $time, $signed(i_m_tdata), i_m_tlast);
                end else begin
                    want = awaited_samples.pop_front();
                    samples_seen++;
                    if (want.last)
                        ends_seen++;
                    if (want.sample == SAMPLE_MAX[SAMPLE_W-1:0] ||
                        want.sample == SAMPLE_MIN[SAMPLE_W-1:0])
                        clips_seen++;
                    if (i_m_tdata !== want.sample)
                        flag_mismatch("sample", $signed(want.sample), $signed(i_m_tdata));
                    if (i_m_tlast !== want.last)
                        flag_mismatch("last", want.last, i_m_tlast);
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_samples.push_back(synthesise_sample(i_s_tdata[0]));
        end
        o_fail_count   <= fails;
        o_pending      <= awaited_samples.size();
        o_samples_seen <= samples_seen;
        o_ends_seen    <= ends_seen;
        o_clips_seen   <= clips_seen;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the additive harmonic synthesiser. A directed opening covers
// reset state, clipping, harmonic count overflow, fractional ratios, empty
// and shortened segments; then randomised settings each drive a run of tick
// words. Bursty input, a patterned output stall and one long hold-off keep
// the handshakes busy; the checker beside the block predicts every sample.
// ----------------------------------------------------------------------------
module testbench;
    import ahs_pkg::*;

    localparam int       CLK_HALF      = 2;
    localparam int       RANDOM_WORDS  = 1500;
    localparam int       HOLD_CYCLES   = 600;
    localparam int       SETTLE_CYCLES = 32;        // beyond one eight-harmonic sample
    localparam int       RUN_LIMIT_NS  = 4000000;
    localparam t_cfg_idx CFG_UNUSED    = 3'd7;      // no register behind it

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } t_sink_mode;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    t_cfg_idx              cfg_idx  = CFG_PHASE_STEP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tlast;
    logic                  hold_req = 1'b0;

    int fail_count;
    int pending;
    int samples_seen;
    int ends_seen;
    int clips_seen;
    int burst_left    = 1;
    int settings_used = 0;
    int restarts_sent = 0;

    always #CLK_HALF clk = ~clk;

    additive_harmonic_synth DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    ahs_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tlast      (m_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_samples_seen (samples_seen),
        .o_ends_seen    (ends_seen),
        .o_clips_seen   (clips_seen)
    );

    // offer one tick word; bursts end in a random gap
    task automatic send_word(input logic restart);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        if (restart)
            restarts_sent++;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // let every sample out, then give the datapath time to go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_put(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // full register set; unused upper data bits carry junk
    task automatic load_setting(input t_cfg c, input bit poke_unused);
        logic [CFG_DATA_W-1:0] junk;
        junk = {$urandom, $urandom};
        reg_put(CFG_PHASE_STEP,     {junk[63:32], c.phase_step});
        reg_put(CFG_START_PHASE,    {junk[31:0], c.start_phase});
        reg_put(CFG_BASE_AMPLITUDE, {junk[63:AMP_W], c.base_amplitude});
        reg_put(CFG_HARMONIC_COUNT, {junk[63:CNT_W], c.harmonic_count});
        reg_put(CFG_RATIO_WORD,     c.ratio_word);
        reg_put(CFG_LEVEL_WORD,     c.level_word);
        reg_put(CFG_SAMPLE_COUNT,   {junk[63:IDX_W], c.sample_count});
        if (poke_unused)
            reg_put(CFG_UNUSED, ~junk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic t_cfg random_setting();
        t_cfg c;
        case ($urandom_range(0, 7))
            0:       c.phase_step = '0;
            1:       c.phase_step = '1;
            2:       c.phase_step = $urandom_range(1, 1 << 20);
            default: c.phase_step = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       c.start_phase = '0;
            1:       c.start_phase = '1;
            default: c.start_phase = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       c.base_amplitude = '0;
            1:       c.base_amplitude = '1;
            default: c.base_amplitude = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       c.harmonic_count = '0;
            1, 2:    c.harmonic_count = $urandom_range(9, 15);
            default: c.harmonic_count = $urandom_range(1, 8);
        endcase
        // integer ratios a third of the time, otherwise any Q4.4 value
        c.ratio_word = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0)
            for (int b = 0; b < 8; b++)
                c.ratio_word[8*b +: 8] = $urandom_range(0, 15) << 4;
        c.level_word = ($urandom_range(0, 5) == 0) ? '1 : {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       c.sample_count = '0;
            1:       c.sample_count = '1;
            2:       c.sample_count = $urandom;
            default: c.sample_count = $urandom_range(1, 16);
        endcase
        return c;
    endfunction

    // output side: windows of different stall patterns, plus one long hold
    initial begin : sink
        int unsigned cyc;
        bit          hold_served;
        cyc         = 0;
        hold_served = 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (hold_req && !hold_served) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served = 1'b1;
            end else begin
                case (cyc[9:8])
                    SINK_OPEN:   m_tready <= 1'b1;
                    SINK_COIN:   m_tready <= $urandom_range(0, 1);
                    SINK_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
                    default:     m_tready <= (cyc % 7) < 5;
                endcase
            end
        end
    end

    initial begin : watchdog
        #RUN_LIMIT_NS;
        $display("Timeout after %0d ns with %0d samples outstanding.", RUN_LIMIT_NS, pending);
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : stimulus
        t_cfg c;
        int   phase_len;
        int   random_sent;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: no harmonics, one-sample segments
        send_word(1'b0);
        send_word(1'b1);
        settle();

        // eight full-scale unit-ratio harmonics: clips both ways, five-sample segments
        c.phase_step     = 32'h1000_0000;
        c.start_phase    = 32'h3000_0000;
        c.base_amplitude = '1;
        c.harmonic_count = 4'd8;
        c.ratio_word     = {8{8'h10}};
        c.level_word     = '1;
        c.sample_count   = 24'd5;
        load_setting(c, 1'b1);
        send_word(1'b1);
        repeat (9) send_word(1'b0);
        settle();

        // count above eight, fractional and zero ratios, tiny amplitude, empty segment
        c.phase_step     = '1;
        c.start_phase    = '1;
        c.base_amplitude = 15'd1;
        c.harmonic_count = 4'd15;
        c.ratio_word     = 64'hFF80_2B18_0801_00F0;
        c.level_word     = 64'h00FF_8001_7F40_C0FF;
        c.sample_count   = '0;
        load_setting(c, 1'b0);
        send_word(1'b1);
        repeat (4) send_word(1'b0);
        settle();

        // long segment, then shortened below the current position
        c.phase_step     = 32'h0123_4567;
        c.start_phase    = 32'h4000_0000;
        c.base_amplitude = 15'h2D2D;
        c.harmonic_count = 4'd3;
        c.ratio_word     = 64'h0000_0000_0030_2010;
        c.level_word     = 64'h0000_0000_0040_80FF;
        c.sample_count   = 24'd20;
        load_setting(c, 1'b0);
        send_word(1'b1);
        repeat (4) send_word(1'b0);
        settle();
        c.sample_count   = 24'd3;
        load_setting(c, 1'b0);
        repeat (3) send_word(1'b0);
        settle();

        // random settings, each followed by a run of ticks
        random_sent = 0;
        while (random_sent < RANDOM_WORDS) begin
            c = random_setting();
            load_setting(c, $urandom_range(0, 7) == 0);
            if (random_sent == 0) begin
                hold_req  <= 1'b1;
                phase_len  = 150;
            end else begin
                phase_len  = $urandom_range(10, 120);
            end
            for (int i = 0; i < phase_len; i++) begin
                if (i == 0)
                    send_word($urandom_range(0, 1));
                else
                    send_word($urandom_range(0, 11) == 0);
                random_sent++;
            end
            settle();
        end

        $display("Covered %0d samples over %0d register settings, %0d of them restarts.",
                 samples_seen, settings_used, restarts_sent);
        $display("Segment ends: %0d, clipped samples: %0d, output hold-off: %0d cycles.",
                 ends_seen, clips_seen, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches, %0d samples never arrived.", fail_count, pending);
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
sv/ahs_pkg.sv
sv/ahs_sine_rom.sv
sv/ahs_sequencer.sv
sv/ahs_datapath.sv
sv/additive_harmonic_synth.sv
test/ahs_checker.sv
test/testbench.sv
